@@ rtl/core/latency_histogram_percentile_assert.svh @@
// Assertion macros for the histogram RTL.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_ASSERT_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LHP_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define LHP_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define LHP_ASSERT_IMP(label, clk, rst, a, c)
`define LHP_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/core/lhp_pkg.sv @@
// Package with types, codes and the bucket bound table of the latency histogram.
package lhp_pkg;
   localparam int NUM_BUCKETS_DEF = 109;
   localparam int MAX_BUCKETS = 109;
   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [13:0] PCT_FULL = 14'd10000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] value;
      logic [13:0] pct;
   } cmd_type;

   function automatic logic [63:0] keep_two_digits(input logic [63:0] x);
      logic [63:0] v;
      logic [63:0] scale;
      v = x;
      scale = 64'd1;
      for (int k = 0; k < 20; k++) begin
         if (v / 64'd10 > 64'd10) begin
            v = v / 64'd10;
            scale = scale * 64'd10;
         end
      end
      return v * scale;
   endfunction

   function automatic logic [63:0] bound_at(input int idx);
      logic [63:0] ip, fp, last, hp, hf, nf, t, t2, cy;
      logic over;
      ip = 64'd2; fp = '0; last = 64'd2; over = 1'b0;
      if (idx == 0) return 64'd1;
      for (int i = 2; i < MAX_BUCKETS; i++) begin
         if (i <= idx && !over) begin
            hp = ip >> 1;
            hf = (fp >> 1) | ({63'd0, ip[0]} << 63);
            nf = fp + hf;
            cy = (nf < fp) ? 64'd1 : 64'd0;
            t = ip + hp;
            if (t < ip) over = 1'b1;
            t2 = t + cy;
            if (t2 < t) over = 1'b1;
            if (!over) begin
               ip = t2;
               fp = nf;
               last = keep_two_digits(ip);
            end
         end
      end
      return last;
   endfunction

   typedef logic [63:0] bound_arr_type [MAX_BUCKETS];

   function automatic bound_arr_type make_bounds();
      bound_arr_type r;
      for (int i = 0; i < MAX_BUCKETS; i++) r[i] = bound_at(i);
      return r;
   endfunction

   localparam bound_arr_type BOUNDS = make_bounds();
endpackage

@@ rtl/core/latency_histogram_percentile.sv @@
// Latency histogram: a record searches the buckets upward from the first, then reads and
// writes its counter (the last bucket skips the search); a duration over several events is divided first.
// A query walks the buckets up to its percentile and then divides within that bucket;
// an empty histogram skips both. A queue of two items separates the front from the back,
// and the back holds off new items while a result waits for rsp_ready.
// Synchronous active-high reset empties the queue and zeroes every counter at once.
module latency_histogram_percentile import lhp_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_duration,
   input  logic [31:0] req_event_count,
   input  logic [13:0] req_percentile_hundredths,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_pct_value_int,
   output logic [7:0]  rsp_pct_value_frac,
   output logic [63:0] rsp_total_count,
   output logic [63:0] rsp_total_sum,
   output logic [63:0] rsp_max_duration
);
   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   lhp_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .duration(req_duration), .event_count(req_event_count),
      .percentile_hundredths(req_percentile_hundredths),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

   lhp_back #(.NUM_BUCKETS(NUM_BUCKETS)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd(cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .pct_value_int(rsp_pct_value_int), .pct_value_frac(rsp_pct_value_frac),
      .total_count(rsp_total_count), .total_sum(rsp_total_sum),
      .max_duration(rsp_max_duration));
endmodule

@@ rtl/core/lhp_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lhp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 109
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/lhp_front.sv @@
// Front end: divides record durations, saturates percentiles, queues commands.
module lhp_front import lhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [63:0] duration,
   input  logic [31:0] event_count,
   input  logic [13:0] percentile_hundredths,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);
   // Divider: restoring, one quotient bit a cycle.
   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        fin_ff, fin_in;
   // Two-entry queue.
   cmd_type     q_ff [2];
   cmd_type     q_in [2];
   logic [1:0]  qn_ff, qn_in;
   cmd_type     push_cmd;
   logic        push, pop;
   logic [32:0] trial;

   assign req_ready = !busy_ff && !fin_ff && (qn_ff != 2'd2);
   assign cmd_valid = (qn_ff != 2'd0);
   assign cmd = q_ff[0];
   assign pop = cmd_valid && cmd_ready;
   assign trial = {rem_ff, quo_ff[63]} - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; quo_in = quo_ff;
      rem_in = rem_ff; den_in = den_ff; fin_in = 1'b0;
      push = 1'b0;
      push_cmd.kind = REQ_RECORD; push_cmd.value = quo_ff; push_cmd.pct = '0;
      if (fin_ff) push = 1'b1;
      if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (req_valid && req_ready) begin
         if (req_type == REQ_RECORD && event_count > 32'd1) begin
            busy_in = 1'b1; cnt_in = 7'd64; quo_in = duration;
            rem_in = '0; den_in = event_count;
         end else if (req_type inside {REQ_RECORD, REQ_QUERY, REQ_CLEAR}) begin
            push = 1'b1;
            push_cmd.kind = req_type;
            push_cmd.value = duration;
            push_cmd.pct = (percentile_hundredths > PCT_FULL) ? PCT_FULL
                                                              : percentile_hundredths;
         end
      end
      q_in = q_ff;
      qn_in = qn_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         qn_in = qn_ff - 2'd1;
      end
      if (push) begin
         q_in[qn_in[0]] = push_cmd;
         qn_in = qn_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; fin_ff <= 1'b0; qn_ff <= '0;
      end else begin
         busy_ff <= busy_in; fin_ff <= fin_in; qn_ff <= qn_in;
      end
      cnt_ff <= cnt_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      q_ff <= q_in;
   end
endmodule

@@ rtl/core/lhp_back.sv @@
// Back end: bucket search, counter updates, clearing and percentile walk.
`include "latency_histogram_percentile_assert.svh"
module lhp_back import lhp_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] pct_value_int,
   output logic [7:0]  pct_value_frac,
   output logic [63:0] total_count,
   output logic [63:0] total_sum,
   output logic [63:0] max_duration
);
   localparam int AW = $clog2(NUM_BUCKETS);
   localparam logic [AW-1:0] LAST = AW'(NUM_BUCKETS - 1);
   localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_RD = 4'd2, S_UPD = 4'd3,
                          S_CLR = 4'd4, S_THR = 4'd5, S_WALK = 4'd6, S_WCHK = 4'd7,
                          S_SEL = 4'd8, S_SELW = 4'd9, S_PREP = 4'd10,
                          S_DIV = 4'd11, S_DONE = 4'd12, S_OUT = 4'd13;

   logic [3:0]    st_ff, st_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [63:0]   val_ff, val_in;
   logic [13:0]   pct_ff, pct_in;
   logic [63:0]   cnt_ff, cnt_in, sum_ff, sum_in, max_ff, max_in;
   logic [MAX_BUCKETS-1:0] vld_ff, vld_in;
   logic [95:0]   thr_ff, thr_in;
   logic [63:0]   acc_ff, acc_in, bc_ff, bc_in;
   logic [63:0]   lo_ff, lo_in, d_ff, d_in;
   logic [95:0]   r_ff, r_in, c_ff, c_in, rem_ff, rem_in;
   logic [71:0]   q_ff, q_in;
   logic [6:0]    k_ff, k_in;
   logic [63:0]   oi_ff, oi_in;
   logic [7:0]    of_ff, of_in;
   logic          ov_ff, ov_in;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [63:0]   rd_raw, rd_cnt, bnd, bnd_prev, sum64;
   logic [95:0]   prod, rem_sh, rem_a, rem_1;

   lhp_ram #(.WIDTH(64), .DEPTH(NUM_BUCKETS)) u_counts (
      .clock(clock), .wr_en(wr_en), .wr_addr(idx_ff), .wr_data(rd_cnt + 64'd1),
      .rd_addr(rd_addr), .rd_data(rd_raw));

   assign rd_cnt = vld_ff[idx_ff] ? rd_raw : 64'd0;
   assign bnd = BOUNDS[idx_ff];
   assign bnd_prev = (idx_ff == '0) ? 64'd0 : BOUNDS[idx_ff - AW'(1)];
   assign wr_en = (st_ff == S_UPD);
   assign rd_addr = idx_in;
   assign sum64 = acc_ff + rd_cnt;
   assign prod = 96'(sum64) * 96'(PCT_FULL);
   // A waiting result holds the back, so the statistics it shows stay put.
   assign cmd_ready = (st_ff == S_IDLE) && (!ov_ff || rsp_ready);
   assign rsp_valid = ov_ff;
   assign pct_value_int = oi_ff;
   assign pct_value_frac = of_ff;
   assign total_count = cnt_ff;
   assign total_sum = sum_ff;
   assign max_duration = max_ff;
   // One quotient bit per step: with r at most c, two conditional subtracts bring rem below c.
   assign rem_sh = {rem_ff[94:0], 1'b0} + ((k_ff < 7'd64 && d_ff[63 - k_ff[5:0]]) ? r_ff : '0);
   assign rem_a = (rem_sh >= c_ff) ? rem_sh - c_ff : rem_sh;
   assign rem_1 = (rem_a >= c_ff) ? rem_a - c_ff : rem_a;

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; val_in = val_ff; pct_in = pct_ff;
      cnt_in = cnt_ff; sum_in = sum_ff; max_in = max_ff; vld_in = vld_ff;
      thr_in = thr_ff; acc_in = acc_ff; bc_in = bc_ff; lo_in = lo_ff; d_in = d_ff;
      r_in = r_ff; c_in = c_ff; rem_in = rem_ff; q_in = q_ff; k_in = k_ff;
      oi_in = oi_ff; of_in = of_ff; ov_in = ov_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: if (cmd_valid && cmd_ready) begin
            val_in = cmd.value; pct_in = cmd.pct; idx_in = '0;
            case (cmd.kind)
               REQ_RECORD: begin
                  cnt_in = cnt_ff + 64'd1; sum_in = sum_ff + cmd.value;
                  if (cmd.value > max_ff) max_in = cmd.value;
                  st_in = (cmd.value >= BOUNDS[NUM_BUCKETS - 1]) ? S_RD : S_SRCH;
                  if (cmd.value >= BOUNDS[NUM_BUCKETS - 1]) idx_in = LAST;
               end
               REQ_QUERY: st_in = S_THR;
               default: st_in = S_CLR;
            endcase
         end
         S_SRCH: begin
            if (bnd >= val_ff || idx_ff == LAST) st_in = S_RD;
            else idx_in = idx_ff + AW'(1);
         end
         S_RD: st_in = S_UPD;
         S_UPD: begin
            vld_in[idx_ff] = 1'b1;
            st_in = S_IDLE;
         end
         S_CLR: begin
            vld_in = '0; cnt_in = '0; sum_in = '0; max_in = '0;
            st_in = S_IDLE;
         end
         S_THR: begin
            if (cnt_ff == 64'd0) begin
               oi_in = '0; of_in = '0; st_in = S_OUT;
            end else begin
               thr_in = 96'(cnt_ff) * 96'(pct_ff);
               acc_in = '0; idx_in = '0; st_in = S_WALK;
            end
         end
         S_WALK: st_in = S_WCHK;
         S_WCHK: begin
            if (prod >= thr_ff) st_in = S_SEL;
            else if (idx_ff == LAST) st_in = S_SEL;
            else begin
               acc_in = sum64; idx_in = idx_ff + AW'(1); st_in = S_WALK;
            end
         end
         S_SEL: begin
            bc_in = rd_cnt;
            lo_in = (idx_ff == '0) ? 64'd0 : bnd_prev + 64'd1;
            d_in = (bnd >= ((idx_ff == '0) ? 64'd0 : bnd_prev + 64'd1))
                   ? bnd - ((idx_ff == '0) ? 64'd0 : bnd_prev + 64'd1) : 64'd0;
            r_in = 96'(acc_ff) * 96'(PCT_FULL);
            st_in = S_SELW;
            if (rd_cnt == 64'd0) begin
               oi_in = bnd; of_in = '0; st_in = S_OUT;
            end
         end
         S_SELW: begin
            c_in = 96'(bc_ff) * 96'(PCT_FULL);
            r_in = (thr_ff >= r_ff) ? thr_ff - r_ff : '0;
            st_in = S_PREP;
         end
         S_PREP: begin
            if (c_ff < r_ff) r_in = c_ff;
            rem_in = '0; q_in = '0; k_in = '0; st_in = S_DIV;
         end
         S_DIV: begin
            rem_in = rem_1;
            q_in = {q_ff[70:0], 1'b0} + 72'(rem_sh >= c_ff) + 72'(rem_a >= c_ff);
            k_in = k_ff + 7'd1;
            if (k_ff == 7'd71) st_in = S_DONE;
         end
         S_DONE: begin
            oi_in = lo_ff + q_ff[71:8]; of_in = q_ff[7:0]; st_in = S_OUT;
         end
         S_OUT: if (!ov_ff) begin
            ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0; vld_ff <= '0;
         cnt_ff <= '0; sum_ff <= '0; max_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; vld_ff <= vld_in;
         cnt_ff <= cnt_in; sum_ff <= sum_in; max_ff <= max_in;
      end
      idx_ff <= idx_in; val_ff <= val_in; pct_ff <= pct_in; thr_ff <= thr_in;
      acc_ff <= acc_in; bc_ff <= bc_in; lo_ff <= lo_in; d_ff <= d_in;
      r_ff <= r_in; c_ff <= c_in; rem_ff <= rem_in; q_ff <= q_in; k_ff <= k_in;
      oi_ff <= oi_in; of_ff <= of_in;
   end

   `LHP_ASSERT_IMP(a_upd_ram, clock, reset, st_ff == S_UPD, wr_en)
   `LHP_ASSERT_NEXT(a_clr_empty, clock, reset, st_ff == S_CLR, cnt_ff == 64'd0)
   `LHP_ASSERT_IMP(a_rem_lt_c, clock, reset, st_ff == S_DIV && k_ff != 7'd0, rem_ff < c_ff)
   `LHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

@@ verif/tb_latency_histogram_percentile.sv @@
// Self-checking testbench for the latency histogram with percentile query.
module tb_latency_histogram_percentile;
   import lhp_pkg::*;

   localparam int NB = NUM_BUCKETS_DEF;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int RANDOM_ITEMS = 1000;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct {
      logic [63:0] vint;
      logic [7:0]  vfrac;
      logic [63:0] cnt;
      logic [63:0] sum;
      logic [63:0] max;
   } stats_type;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] dur;
      logic [31:0] events;
      logic [13:0] pct;
      bit          typed;
      stats_type   want;
   } req_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [63:0] req_duration;
   logic [31:0] req_event_count;
   logic [13:0] req_percentile_hundredths;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_pct_value_int;
   logic [7:0]  rsp_pct_value_frac;
   logic [63:0] rsp_total_count;
   logic [63:0] rsp_total_sum;
   logic [63:0] rsp_max_duration;

   logic [63:0] bounds [NB];
   logic [63:0] hist_counts [NB];
   logic [63:0] n_samples, sum_samples, max_sample;
   stats_type   pending_stats [$];
   req_row_type directed [$];
   int          errors;
   int          cycles;

   latency_histogram_percentile DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [63:0] two_digits(input logic [63:0] x);
      logic [63:0] scale;
      scale = 64'd1;
      while (x / 64'd10 > 64'd10) begin
         x = x / 64'd10;
         scale = scale * 64'd10;
      end
      return x * scale;
   endfunction

   // Bounds grow by 1.5 in 64.64 fixed point until the integer part overflows.
   task automatic build_bounds();
      logic [63:0] ip, fp, last, hf;
      logic [64:0] fsum, isum, isum2;
      bit over;
      ip = 64'd2; fp = '0; last = 64'd2; over = 0;
      bounds[0] = 64'd1;
      bounds[1] = 64'd2;
      for (int i = 2; i < NB; i++) begin
         if (!over) begin
            hf = {ip[0], fp[63:1]};
            fsum = {1'b0, fp} + {1'b0, hf};
            isum = {1'b0, ip} + {1'b0, ip >> 1};
            isum2 = {1'b0, isum[63:0]} + {64'd0, fsum[64]};
            if (isum[64] || isum2[64]) over = 1;
            else begin
               ip = isum2[63:0];
               fp = fsum[63:0];
               last = two_digits(ip);
            end
         end
         bounds[i] = last;
      end
   endtask

   function automatic int bucket_index(input logic [63:0] v);
      if (v >= bounds[NB-1]) return NB - 1;
      for (int i = 0; i < NB; i++) if (bounds[i] >= v) return i;
      return NB - 1;
   endfunction

   function automatic stats_type query_stats(input logic [13:0] pct_in);
      stats_type s;
      logic [127:0] thr, r, c, a;
      logic [191:0] num, q;
      logic [63:0] acc, lower, upper, span, cnt, p;
      int b;
      s.cnt = n_samples; s.sum = sum_samples; s.max = max_sample;
      s.vint = '0; s.vfrac = '0;
      if (n_samples == 0) return s;
      p = (pct_in > PCT_FULL) ? 64'd10000 : {50'd0, pct_in};
      thr = {64'd0, n_samples} * {64'd0, p};
      acc = '0;
      for (b = 0; b < NB; b++) begin
         cnt = acc + hist_counts[b];
         if ({64'd0, cnt} * 128'd10000 >= thr) break;
         acc = cnt;
      end
      // Only reachable once the counters have wrapped.
      if (b >= NB) begin
         b = NB - 1;
         acc = acc - hist_counts[b];
      end
      lower = (b == 0) ? 64'd0 : bounds[b-1] + 64'd1;
      upper = bounds[b];
      cnt = hist_counts[b];
      if (cnt == 0) begin
         s.vint = upper;
         return s;
      end
      span = (upper >= lower) ? upper - lower : 64'd0;
      a = {64'd0, acc} * 128'd10000;
      r = (thr >= a) ? thr - a : '0;
      c = {64'd0, cnt} * 128'd10000;
      if (c < r) r = c;
      num = ({64'd0, r} * {128'd0, span}) << 8;
      q = num / {64'd0, c};
      s.vint = lower + q[71:8];
      s.vfrac = q[7:0];
      return s;
   endfunction

   // Advances the histogram state for one accepted item; returns 1 if a result follows.
   function automatic bit apply_request(input req_row_type it, output stats_type s);
      logic [63:0] v;
      s = '{default: '0};
      case (it.kind)
         REQ_RECORD: begin
            v = (it.events > 32'd1) ? it.dur / {32'd0, it.events} : it.dur;
            n_samples = n_samples + 1;
            sum_samples = sum_samples + v;
            if (v > max_sample) max_sample = v;
            hist_counts[bucket_index(v)] = hist_counts[bucket_index(v)] + 1;
            return 0;
         end
         REQ_QUERY: begin
            s = query_stats(it.pct);
            return 1;
         end
         REQ_CLEAR: begin
            foreach (hist_counts[i]) hist_counts[i] = '0;
            n_samples = '0; sum_samples = '0; max_sample = '0;
            return 0;
         end
         default: return 0;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic add_row(input req_row_type it);
      directed = {directed, it};
   endtask

   task automatic send_request(input req_row_type it);
      stats_type s;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = it.kind;
      req_duration = it.dur;
      req_event_count = it.events;
      req_percentile_hundredths = it.pct;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (apply_request(it, s))
         pending_stats.insert(pending_stats.size(), it.typed ? it.want : s);
      @(negedge clock);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      stats_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $error("result arrived with no query outstanding");
            errors++;
         end else begin
            w = pending_stats.pop_front();
            compare_field("pct_value_int", w.vint, rsp_pct_value_int);
            compare_field("pct_value_frac", {56'd0, w.vfrac}, {56'd0, rsp_pct_value_frac});
            compare_field("total_count", w.cnt, rsp_total_count);
            compare_field("total_sum", w.sum, rsp_total_sum);
            compare_field("max_duration", w.max, rsp_max_duration);
         end
      end
   end

   // Result-side back pressure: calm stretches alternate with stalls of mixed length.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < 70) rsp_ready = 1'b1;
         else begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 99) < 85 ? $urandom_range(1, 4)
                                               : $urandom_range(20, 80)) @(negedge clock);
            rsp_ready = 1'b1;
            repeat ($urandom_range(0, 40)) @(negedge clock);
         end
      end
   end

   function automatic req_row_type row(input logic [1:0] k, input logic [63:0] d,
                                       input logic [31:0] e, input logic [13:0] p);
      row = '{kind: k, dur: d, events: e, pct: p, typed: 0, want: '{default: '0}};
   endfunction

   function automatic req_row_type random_row();
      int sel;
      logic [63:0] d;
      logic [31:0] e;
      logic [13:0] p;
      sel = $urandom_range(0, 99);
      d = {$urandom(), $urandom()} >> $urandom_range(0, 63);
      case ($urandom_range(0, 5))
         0, 1, 2: e = $urandom_range(0, 1);
         3: e = $urandom_range(2, 20);
         4: e = $urandom();
         default: e = $urandom() >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 9) == 0) p = 14'($urandom_range(0, 16383));
      else p = 14'($urandom_range(0, 10000));
      if (sel < 70) return row(REQ_RECORD, d, e, p);
      if (sel < 95) return row(REQ_QUERY, d, e, p);
      if (sel < 98) return row(REQ_CLEAR, d, e, p);
      return row(REQ_UNKNOWN, d, e, p);
   endfunction

   initial begin
      req_row_type it;
      int wait_cycles;
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_RECORD;
      req_duration = '0;
      req_event_count = '0;
      req_percentile_hundredths = '0;
      build_bounds();
      foreach (hist_counts[i]) hist_counts[i] = '0;
      n_samples = '0; sum_samples = '0; max_sample = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // An empty histogram answers all zeros.
      it = row(REQ_QUERY, '0, '0, 14'd5000); it.typed = 1; add_row(it);
      add_row(row(REQ_RECORD, 64'd0, 32'd0, '0));
      add_row(row(REQ_RECORD, '1, 32'd1, '1));
      add_row(row(REQ_RECORD, '1, '1, '0));
      add_row(row(REQ_RECORD, 64'd1000, 32'd3, '0));
      add_row(row(REQ_RECORD, 64'd1, 32'd0, '0));
      add_row(row(REQ_RECORD, 64'd2, 32'd2, '0));
      add_row(row(REQ_QUERY, '1, '1, 14'd0));
      add_row(row(REQ_QUERY, '0, '0, 14'd10000));
      add_row(row(REQ_QUERY, '0, '0, 14'h3FFF));
      add_row(row(REQ_QUERY, '0, '0, 14'd5000));
      add_row(row(REQ_UNKNOWN, '1, '1, '1));
      add_row(row(REQ_QUERY, '0, '0, 14'd2500));
      add_row(row(REQ_CLEAR, '0, '0, '0));
      it = row(REQ_QUERY, '0, '0, 14'd10000); it.typed = 1; add_row(it);
      add_row(row(REQ_RECORD, 64'd7, 32'd0, '0));
      // With nothing in the first bucket, the zero percentile lands on an empty bucket.
      add_row(row(REQ_QUERY, '0, '0, 14'd0));
      add_row(row(REQ_QUERY, '0, '0, 14'd1));
      add_row(row(REQ_QUERY, '0, '0, 14'd10000));
      add_row(row(REQ_CLEAR, '0, '0, '0));

      foreach (directed[i]) send_request(directed[i]);
      repeat (RANDOM_ITEMS) send_request(random_row());
      req_valid = 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 500) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
